// ===== hw/rtl/kafm_pkg.sv =====
// Shared constants and types for the keyed alarm frame matcher.
`timescale 1ns / 1ps

package kafm_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 3;
   localparam int unsigned EVT_W  = 3;
   localparam int unsigned KEY_N  = 5;
   localparam int unsigned IDX_W  = 3;

   // Default command byte values.
   localparam logic [BYTE_W-1:0] CMD_BATTERY_DEF = 8'd2;
   localparam logic [BYTE_W-1:0] CMD_STOLEN_DEF  = 8'd3;
   localparam logic [BYTE_W-1:0] CMD_RAISED_DEF  = 8'd4;
   localparam logic [BYTE_W-1:0] CMD_FELL_DEF    = 8'd5;
   localparam logic [BYTE_W-1:0] CMD_WIRE_DEF    = 8'd6;

   // Alarm event codes.
   localparam logic [EVT_W-1:0] EVT_NONE    = 3'd0;
   localparam logic [EVT_W-1:0] EVT_BATTERY = 3'd1;
   localparam logic [EVT_W-1:0] EVT_STOLEN  = 3'd2;
   localparam logic [EVT_W-1:0] EVT_RAISED  = 3'd3;
   localparam logic [EVT_W-1:0] EVT_FELL    = 3'd4;
   localparam logic [EVT_W-1:0] EVT_WIRE    = 3'd5;

   // Frame positions with a meaning of their own.
   localparam logic [POS_W-1:0] POS_START   = 3'd0;
   localparam logic [POS_W-1:0] POS_PCMD    = 3'd1;
   localparam logic [POS_W-1:0] POS_COMMAND = 3'd5;
   localparam logic [POS_W-1:0] POS_LAST    = 3'd6;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] REG_KEY_0    = 3'd0;
   localparam logic [IDX_W-1:0] REG_KEY_1    = 3'd1;
   localparam logic [IDX_W-1:0] REG_KEY_2    = 3'd2;
   localparam logic [IDX_W-1:0] REG_KEY_3    = 3'd3;
   localparam logic [IDX_W-1:0] REG_KEY_4    = 3'd4;
   localparam logic [IDX_W-1:0] REG_PAIR_HDR = 3'd5;
   localparam logic [IDX_W-1:0] REG_PAIR_CMD = 3'd6;

   typedef logic [KEY_N-1:0][BYTE_W-1:0] key_set_type;

   typedef struct packed {
      logic [EVT_W-1:0] alarm_event;
      logic             pair_done;
      logic [POS_W-1:0] next_pos;
   } step_result_type;

endpackage

// ===== hw/rtl/kafm_step.sv =====
// Per-byte frame match: next position, alarm event and pairing completion.
`timescale 1ns / 1ps

module kafm_step #(
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_BATTERY = kafm_pkg::CMD_BATTERY_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_STOLEN  = kafm_pkg::CMD_STOLEN_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_RAISED  = kafm_pkg::CMD_RAISED_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_FELL    = kafm_pkg::CMD_FELL_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_WIRE    = kafm_pkg::CMD_WIRE_DEF
) (
   input  logic [kafm_pkg::POS_W-1:0]  pos,
   input  logic [kafm_pkg::BYTE_W-1:0] rx_byte,
   input  logic                        pairing_mode,
   input  kafm_pkg::key_set_type       key_bytes,
   input  logic [kafm_pkg::BYTE_W-1:0] pair_header,
   input  logic [kafm_pkg::BYTE_W-1:0] pair_command,
   output kafm_pkg::step_result_type   result
);

   logic [kafm_pkg::BYTE_W-1:0] key_sel;
   logic [kafm_pkg::EVT_W-1:0]  cmd_event;
   logic [kafm_pkg::POS_W-1:0]  pos_inc;

   assign pos_inc = pos + kafm_pkg::POS_W'(1);

   // Expected key byte for the current position (positions 0..4 only).
   always_comb begin
      case (pos)
         3'd0:    key_sel = key_bytes[0];
         3'd1:    key_sel = key_bytes[1];
         3'd2:    key_sel = key_bytes[2];
         3'd3:    key_sel = key_bytes[3];
         3'd4:    key_sel = key_bytes[4];
         default: key_sel = '0;
      endcase
   end

   // First match wins when command values coincide.
   always_comb begin
      if (rx_byte == CMD_BATTERY)     cmd_event = kafm_pkg::EVT_BATTERY;
      else if (rx_byte == CMD_STOLEN) cmd_event = kafm_pkg::EVT_STOLEN;
      else if (rx_byte == CMD_RAISED) cmd_event = kafm_pkg::EVT_RAISED;
      else if (rx_byte == CMD_FELL)   cmd_event = kafm_pkg::EVT_FELL;
      else if (rx_byte == CMD_WIRE)   cmd_event = kafm_pkg::EVT_WIRE;
      else                            cmd_event = kafm_pkg::EVT_NONE;
   end

   always_comb begin
      result.alarm_event = kafm_pkg::EVT_NONE;
      result.pair_done   = 1'b0;
      result.next_pos    = kafm_pkg::POS_START;
      if (!pairing_mode) begin
         if (pos < kafm_pkg::POS_COMMAND) begin
            if (rx_byte == key_sel) result.next_pos = pos_inc;
         end else if (pos == kafm_pkg::POS_COMMAND) begin
            result.alarm_event = cmd_event;
         end
      end else begin
         if (pos == kafm_pkg::POS_START) begin
            if (rx_byte == pair_header) result.next_pos = pos_inc;
         end else if (pos == kafm_pkg::POS_PCMD) begin
            if (rx_byte == pair_command) result.next_pos = pos_inc;
         end else if (pos <= kafm_pkg::POS_COMMAND) begin
            result.next_pos = pos_inc;
         end else if (pos == kafm_pkg::POS_LAST) begin
            result.pair_done = 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/keyed_alarm_frame_matcher.sv =====
// Top level: keyed alarm / pairing frame matcher with byte stream in and result out.
// Each beat passes the input register, then the result register, which drives rsp_*.
// Throughput: one beat per cycle while rsp_ready holds; one compare and increment sits
//   between the input and result registers, and a new beat is taken while a result waits.
// Reset (synchronous, active high) clears both valids, the frame position and all
//   configuration registers.
`timescale 1ns / 1ps

module keyed_alarm_frame_matcher #(
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_BATTERY = kafm_pkg::CMD_BATTERY_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_STOLEN  = kafm_pkg::CMD_STOLEN_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_RAISED  = kafm_pkg::CMD_RAISED_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_FELL    = kafm_pkg::CMD_FELL_DEF,
   parameter logic [kafm_pkg::BYTE_W-1:0] CMD_WIRE    = kafm_pkg::CMD_WIRE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write port
   input  logic                        csr_we,
   input  logic [kafm_pkg::IDX_W-1:0]  csr_index,
   input  logic [kafm_pkg::BYTE_W-1:0] csr_wdata,
   // byte stream in
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [kafm_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                        req_pairing_mode,
   // results out
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [kafm_pkg::EVT_W-1:0]  rsp_alarm_event,
   output logic                        rsp_pair_done,
   output logic [kafm_pkg::POS_W-1:0]  rsp_frame_position_out
);

   // Configuration registers
   kafm_pkg::key_set_type       key_ff;
   logic [kafm_pkg::BYTE_W-1:0] pair_hdr_ff;
   logic [kafm_pkg::BYTE_W-1:0] pair_cmd_ff;

   // Input stage
   logic                        in_valid_ff;
   logic [kafm_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_pairing_ff;

   // Frame state
   logic [kafm_pkg::POS_W-1:0]  pos_ff;
   logic [kafm_pkg::POS_W-1:0]  pos_in;

   // Result stage
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [kafm_pkg::EVT_W-1:0]  out_event_ff;
   logic                        out_done_ff;
   logic [kafm_pkg::POS_W-1:0]  out_pos_ff;

   kafm_pkg::step_result_type   step_res;
   logic                        req_take;
   logic                        out_load;

   // Input beat moves to the result stage when that stage is empty or draining.
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign req_take  = req_valid && req_ready;

   kafm_step #(
      .CMD_BATTERY (CMD_BATTERY),
      .CMD_STOLEN  (CMD_STOLEN),
      .CMD_RAISED  (CMD_RAISED),
      .CMD_FELL    (CMD_FELL),
      .CMD_WIRE    (CMD_WIRE)
   ) u_step (
      .pos          (pos_ff),
      .rx_byte      (in_byte_ff),
      .pairing_mode (in_pairing_ff),
      .key_bytes    (key_ff),
      .pair_header  (pair_hdr_ff),
      .pair_command (pair_cmd_ff),
      .result       (step_res)
   );

   // Position advances only when a beat is actually consumed.
   assign pos_in       = out_load ? step_res.next_pos : pos_ff;
   assign out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp_ready);

   // Config writes; indexes past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         pair_hdr_ff <= '0;
         pair_cmd_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            kafm_pkg::REG_KEY_0:    key_ff[0]   <= csr_wdata;
            kafm_pkg::REG_KEY_1:    key_ff[1]   <= csr_wdata;
            kafm_pkg::REG_KEY_2:    key_ff[2]   <= csr_wdata;
            kafm_pkg::REG_KEY_3:    key_ff[3]   <= csr_wdata;
            kafm_pkg::REG_KEY_4:    key_ff[4]   <= csr_wdata;
            kafm_pkg::REG_PAIR_HDR: pair_hdr_ff <= csr_wdata;
            kafm_pkg::REG_PAIR_CMD: pair_cmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= kafm_pkg::POS_START;
      end else begin
         in_valid_ff  <= req_take || (in_valid_ff && !out_load);
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff    <= req_rx_byte;
         in_pairing_ff <= req_pairing_mode;
      end
      if (out_load) begin
         out_event_ff <= step_res.alarm_event;
         out_done_ff  <= step_res.pair_done;
         out_pos_ff   <= step_res.next_pos;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_alarm_event        = out_event_ff;
   assign rsp_pair_done          = out_done_ff;
   assign rsp_frame_position_out = out_pos_ff;

endmodule

// ===== hw/rtl/kafm_checker.sv =====
// Port-level checks for the frame matcher, bound to the top level.
`timescale 1ns / 1ps

module kafm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [kafm_pkg::EVT_W-1:0]  rsp_alarm_event,
   input logic                        rsp_pair_done,
   input logic [kafm_pkg::POS_W-1:0]  rsp_frame_position_out
);

   // Stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alarm_event)
         && $stable(rsp_pair_done) && $stable(rsp_frame_position_out))
      else $error("result beat changed while stalled");

   // A completed pairing frame always restarts the position.
   a_pair_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_done |-> rsp_frame_position_out == kafm_pkg::POS_START)
      else $error("pair_done without position reset");

   // An alarm event ends a frame, never together with pair_done.
   a_event_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alarm_event != kafm_pkg::EVT_NONE
         |-> rsp_frame_position_out == kafm_pkg::POS_START && !rsp_pair_done)
      else $error("alarm event with live frame or pair_done");

   // Position seven and event codes beyond wire broken never appear.
   a_codes_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_position_out <= kafm_pkg::POS_LAST
         && rsp_alarm_event <= kafm_pkg::EVT_WIRE)
      else $error("illegal position or event code");

endmodule

bind keyed_alarm_frame_matcher kafm_checker u_kafm_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_alarm_event        (rsp_alarm_event),
   .rsp_pair_done          (rsp_pair_done),
   .rsp_frame_position_out (rsp_frame_position_out)
);

// ===== bench/keyed_alarm_frame_matcher_tb.sv =====
// Self-checking bench for the keyed alarm frame matcher: directed table, then random frames.
`timescale 1ns / 1ps

module keyed_alarm_frame_matcher_tb;

   // Run length and limits.
   localparam int          PHASE_BEATS = 80;      // random beats per key setting
   localparam int          PHASE_N     = 5;
   localparam int unsigned CYCLE_LIMIT = 100_000; // watchdog bound on the whole run
   localparam int          IDLE_PCT    = 9;       // chance of a gap / stall per cycle

   // Index past the last register; writes to it must change nothing.
   localparam logic [kafm_pkg::IDX_W-1:0] REG_SPARE = 3'd7;

   // One row of the directed table. Rows with fixed_want set carry the result
   // read straight off the frame format; the rest go through the predictor.
   typedef struct packed {
      logic [kafm_pkg::BYTE_W-1:0] rx;
      logic                        pairing;
      logic                        fixed_want;
      kafm_pkg::step_result_type   want;
   } probe_row_type;

   localparam kafm_pkg::step_result_type NO_WANT =
      '{kafm_pkg::EVT_NONE, 1'b0, kafm_pkg::POS_START};

   // Directed rows. The key setting below is loaded just before row PROBE_CFG_AT:
   //   keys A5 5A FF 00 3C, pair header C3, pair command 81.
   localparam int PROBE_N      = 37;
   localparam int PROBE_CFG_AT = 3;
   localparam probe_row_type PROBES [0:PROBE_N-1] = '{
      // registers still at reset (all zero)
      '{8'hFF, 1'b0, 1'b1, '{kafm_pkg::EVT_NONE, 1'b0, kafm_pkg::POS_START}}, // key 0 miss
      '{8'h00, 1'b1, 1'b1, '{kafm_pkg::EVT_NONE, 1'b0, kafm_pkg::POS_PCMD}},  // header hit
      '{8'h01, 1'b1, 1'b1, '{kafm_pkg::EVT_NONE, 1'b0, kafm_pkg::POS_START}}, // cmd miss
      // miss at position 1 drops to start; the missing byte is not retried
      '{8'hA5, 1'b0, 1'b0, NO_WANT},
      '{8'hA5, 1'b0, 1'b0, NO_WANT},
      // full alarm frame, battery
      '{8'hA5, 1'b0, 1'b0, NO_WANT},
      '{8'h5A, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h3C, 1'b0, 1'b0, NO_WANT},
      '{8'h02, 1'b0, 1'b1, '{kafm_pkg::EVT_BATTERY, 1'b0, kafm_pkg::POS_START}},
      // full alarm frame, unknown command still closes the frame
      '{8'hA5, 1'b0, 1'b0, NO_WANT},
      '{8'h5A, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b0, NO_WANT},
      '{8'h00, 1'b0, 1'b0, NO_WANT},
      '{8'h3C, 1'b0, 1'b0, NO_WANT},
      '{8'hFF, 1'b0, 1'b1, '{kafm_pkg::EVT_NONE, 1'b0, kafm_pkg::POS_START}},
      // pairing bytes up to position 5, then alarm mode takes the command
      '{8'hC3, 1'b1, 1'b0, NO_WANT},
      '{8'h81, 1'b1, 1'b0, NO_WANT},
      '{8'h00, 1'b1, 1'b0, NO_WANT},
      '{8'hFF, 1'b1, 1'b0, NO_WANT},
      '{8'h5A, 1'b1, 1'b0, NO_WANT},
      '{8'h06, 1'b0, 1'b1, '{kafm_pkg::EVT_WIRE, 1'b0, kafm_pkg::POS_START}},
      // complete pairing frame
      '{8'hC3, 1'b1, 1'b0, NO_WANT},
      '{8'h81, 1'b1, 1'b0, NO_WANT},
      '{8'h00, 1'b1, 1'b0, NO_WANT},
      '{8'hFF, 1'b1, 1'b0, NO_WANT},
      '{8'h12, 1'b1, 1'b0, NO_WANT},
      '{8'hED, 1'b1, 1'b0, NO_WANT},
      '{8'h7E, 1'b1, 1'b1, '{kafm_pkg::EVT_NONE, 1'b1, kafm_pkg::POS_START}},
      // pairing up to position 6, then an alarm-mode byte: back to start, no event
      '{8'hC3, 1'b1, 1'b0, NO_WANT},
      '{8'h81, 1'b1, 1'b0, NO_WANT},
      '{8'hAA, 1'b1, 1'b0, NO_WANT},
      '{8'h55, 1'b1, 1'b0, NO_WANT},
      '{8'h0F, 1'b1, 1'b0, NO_WANT},
      '{8'hF0, 1'b1, 1'b0, NO_WANT},
      '{8'hA5, 1'b0, 1'b1, '{kafm_pkg::EVT_NONE, 1'b0, kafm_pkg::POS_START}}
   };

   // Clock and reset. Every input is known from time zero.
   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          csr_we           = 1'b0;
   logic [kafm_pkg::IDX_W-1:0]    csr_index        = '0;
   logic [kafm_pkg::BYTE_W-1:0]   csr_wdata        = '0;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [kafm_pkg::BYTE_W-1:0]   req_rx_byte      = '0;
   logic                          req_pairing_mode = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic [kafm_pkg::EVT_W-1:0]    rsp_alarm_event;
   logic                          rsp_pair_done;
   logic [kafm_pkg::POS_W-1:0]    rsp_frame_position_out;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   keyed_alarm_frame_matcher dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_rx_byte            (req_rx_byte),
      .req_pairing_mode       (req_pairing_mode),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_alarm_event        (rsp_alarm_event),
      .rsp_pair_done          (rsp_pair_done),
      .rsp_frame_position_out (rsp_frame_position_out)
   );

   // Shadow of the register file and of the frame position, as the block
   // should hold them after every accepted beat.
   logic [kafm_pkg::BYTE_W-1:0] csr_shadow [0:6] = '{default: '0};
   logic [kafm_pkg::POS_W-1:0]  match_pos = kafm_pkg::POS_START;

   kafm_pkg::step_result_type results_due [$];   // one entry per accepted byte, oldest first
   int          beats_done  = 0;
   int          fail_count  = 0;
   bit          steady      = 1'b0;    // no gaps or stalls while set
   int unsigned cycle_count = 0;

   // Command byte to alarm event; first match wins if commands ever collide.
   function automatic logic [kafm_pkg::EVT_W-1:0] alarm_of(
         input logic [kafm_pkg::BYTE_W-1:0] cmd);
      if (cmd == kafm_pkg::CMD_BATTERY_DEF) return kafm_pkg::EVT_BATTERY;
      if (cmd == kafm_pkg::CMD_STOLEN_DEF)  return kafm_pkg::EVT_STOLEN;
      if (cmd == kafm_pkg::CMD_RAISED_DEF)  return kafm_pkg::EVT_RAISED;
      if (cmd == kafm_pkg::CMD_FELL_DEF)    return kafm_pkg::EVT_FELL;
      if (cmd == kafm_pkg::CMD_WIRE_DEF)    return kafm_pkg::EVT_WIRE;
      return kafm_pkg::EVT_NONE;
   endfunction

   // Advance the frame position by one byte and return the result it gives.
   function automatic kafm_pkg::step_result_type match_byte(
         input logic [kafm_pkg::BYTE_W-1:0] rx, input logic pairing);
      kafm_pkg::step_result_type r;
      logic [kafm_pkg::POS_W-1:0] nxt;
      r   = NO_WANT;
      nxt = kafm_pkg::POS_START;   // any miss, and position 7, land here
      if (!pairing) begin
         if (match_pos < kafm_pkg::POS_COMMAND) begin
            if (rx == csr_shadow[match_pos]) nxt = match_pos + 1'b1;
         end else if (match_pos == kafm_pkg::POS_COMMAND) begin
            r.alarm_event = alarm_of(rx);
         end
         // position 6 in alarm mode: back to start, nothing reported
      end else begin
         if (match_pos == kafm_pkg::POS_START) begin
            if (rx == csr_shadow[kafm_pkg::REG_PAIR_HDR]) nxt = kafm_pkg::POS_PCMD;
         end else if (match_pos == kafm_pkg::POS_PCMD) begin
            if (rx == csr_shadow[kafm_pkg::REG_PAIR_CMD]) nxt = kafm_pkg::POS_PCMD + 1'b1;
         end else if (match_pos < kafm_pkg::POS_LAST) begin
            nxt = match_pos + 1'b1;   // payload bytes, any value
         end else if (match_pos == kafm_pkg::POS_LAST) begin
            r.pair_done = 1'b1;
         end
      end
      match_pos = nxt;
      r.next_pos = nxt;
      return r;
   endfunction

   // Present one byte, hold it until taken, then log what it should give.
   task automatic drive_beat(input logic [kafm_pkg::BYTE_W-1:0] rx, input logic pairing,
                             input logic fixed_want,
                             input kafm_pkg::step_result_type want_in);
      kafm_pkg::step_result_type want;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_rx_byte      <= rx;
      req_pairing_mode <= pairing;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      want = match_byte(rx, pairing);
      results_due.push_back(fixed_want ? want_in : want);
      beats_done++;
   endtask

   // Drop valid and wait out every result still owed. Every byte gives one
   // result, so an empty queue means the pipe is empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [kafm_pkg::IDX_W-1:0] idx,
                            input logic [kafm_pkg::BYTE_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx <= kafm_pkg::REG_PAIR_CMD) csr_shadow[idx] = val;
      @(posedge clock);
   endtask

   // Load all seven registers back to back; optionally poke the unused index
   // afterwards so a bad decode would clobber a live register.
   task automatic load_setting(input logic [6:0][kafm_pkg::BYTE_W-1:0] vals,
                               input bit poke_spare);
      int i;
      for (i = 0; i <= int'(kafm_pkg::REG_PAIR_CMD); i++)
         write_reg(kafm_pkg::IDX_W'(i), vals[i]);
      if (poke_spare) write_reg(REG_SPARE, ~vals[0]);
      csr_we <= 1'b0;
   endtask

   // One random sequence: mostly well-formed frames with random content,
   // some corrupted, the rest noise.
   task automatic emit_sequence();
      int kind, n, i;
      logic [kafm_pkg::BYTE_W-1:0] b;
      logic m;
      kind = $urandom_range(99);
      if (kind < 45) begin
         // alarm frame; a key byte or mode bit is now and then broken
         for (i = 0; i < kafm_pkg::KEY_N; i++) begin
            b = ($urandom_range(99) < 4) ? kafm_pkg::BYTE_W'($urandom_range(255))
                                         : csr_shadow[i];
            m = ($urandom_range(99) < 3);
            drive_beat(b, m, 1'b0, NO_WANT);
         end
         n = $urandom_range(6);
         b = (n < 5) ? kafm_pkg::CMD_BATTERY_DEF + kafm_pkg::BYTE_W'(n)
                     : kafm_pkg::BYTE_W'($urandom_range(255));
         m = (n == 6) ? 1'($urandom_range(1)) : 1'b0;
         drive_beat(b, m, 1'b0, NO_WANT);
      end else if (kind < 75) begin
         // pairing frame: header, command, five payload bytes
         b = ($urandom_range(99) < 4) ? kafm_pkg::BYTE_W'($urandom_range(255))
                                      : csr_shadow[kafm_pkg::REG_PAIR_HDR];
         drive_beat(b, 1'b1, 1'b0, NO_WANT);
         b = ($urandom_range(99) < 4) ? kafm_pkg::BYTE_W'($urandom_range(255))
                                      : csr_shadow[kafm_pkg::REG_PAIR_CMD];
         drive_beat(b, 1'b1, 1'b0, NO_WANT);
         for (i = 0; i < 5; i++)
            drive_beat(kafm_pkg::BYTE_W'($urandom_range(255)), ($urandom_range(99) >= 3),
                       1'b0, NO_WANT);
      end else begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            drive_beat(kafm_pkg::BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                       1'b0, NO_WANT);
      end
   endtask

   // Result side: random back-pressure, and every beat taken is checked
   // against the oldest owed result.
   always @(posedge clock) begin : result_check
      kafm_pkg::step_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("result beat with nothing owed: event %0d done %0d pos %0d",
                      rsp_alarm_event, rsp_pair_done, rsp_frame_position_out);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_alarm_event !== want.alarm_event) begin
                  $error("alarm_event: expected %0d, got %0d",
                         want.alarm_event, rsp_alarm_event);
                  fail_count++;
               end
               if (rsp_pair_done !== want.pair_done) begin
                  $error("pair_done: expected %0d, got %0d", want.pair_done, rsp_pair_done);
                  fail_count++;
               end
               if (rsp_frame_position_out !== want.next_pos) begin
                  $error("frame_position_out: expected %0d, got %0d",
                         want.next_pos, rsp_frame_position_out);
                  fail_count++;
               end
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int r, p, i, start;
      bit paused;
      logic [6:0][kafm_pkg::BYTE_W-1:0] setting;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (r = 0; r < PROBE_N; r++) begin
         if (r == PROBE_CFG_AT) begin
            settle();
            load_setting({8'h81, 8'hC3, 8'h3C, 8'h00, 8'hFF, 8'h5A, 8'hA5}, 1'b1);
         end
         drive_beat(PROBES[r].rx, PROBES[r].pairing, PROBES[r].fixed_want, PROBES[r].want);
      end

      // Random phases, one key setting each. Phase 3 runs with no gaps or
      // stalls on either side; every phase drains once halfway through.
      for (p = 0; p < PHASE_N; p++) begin
         settle();
         case (p)
            0: setting = '1;
            1, 4: for (i = 0; i <= int'(kafm_pkg::REG_PAIR_CMD); i++)
                     setting[i] = kafm_pkg::BYTE_W'($urandom_range(255));
            2: begin
               // keys equal to the command codes, pair header equal to pair command
               for (i = 0; i < kafm_pkg::KEY_N; i++)
                  setting[i] = kafm_pkg::CMD_BATTERY_DEF + kafm_pkg::BYTE_W'(i);
               setting[kafm_pkg::REG_PAIR_HDR] = kafm_pkg::BYTE_W'($urandom_range(255));
               setting[kafm_pkg::REG_PAIR_CMD] = setting[kafm_pkg::REG_PAIR_HDR];
            end
            default: setting = '0;
         endcase
         load_setting(setting, 1'b0);
         steady = (p == 3);
         start  = beats_done;
         paused = 1'b0;
         while (beats_done - start < PHASE_BEATS) begin
            emit_sequence();
            if (!paused && beats_done - start >= PHASE_BEATS / 2) begin
               settle();
               paused = 1'b1;
            end
         end
      end

      steady = 1'b0;
      settle();
      repeat (4) @(posedge clock);   // catch any stray result after the last one
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
